@@ hw/rtl/bsmdu_pkg.sv @@
// ----------------------------------------------------------------------------
// Bit-serial multiply / divide unit package
// Shared types, register addresses and codes for the multiply / divide unit.
// ----------------------------------------------------------------------------
package bsmdu_pkg;

  // Request operation codes.
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_CLOCK = 2'd1,
    ST_APPLY = 2'd2,
    ST_RESP  = 2'd3
  } seq_state_e;

  // Register addresses.
  localparam logic [15:0] AddrMultiplicand = 16'h4202;
  localparam logic [15:0] AddrMulStart     = 16'h4203;
  localparam logic [15:0] AddrDividendLo   = 16'h4204;
  localparam logic [15:0] AddrDividendHi   = 16'h4205;
  localparam logic [15:0] AddrDivStart     = 16'h4206;
  localparam logic [15:0] AddrQuotLo       = 16'h4214;
  localparam logic [15:0] AddrQuotHi       = 16'h4215;
  localparam logic [15:0] AddrProdRemLo    = 16'h4216;
  localparam logic [15:0] AddrProdRemHi    = 16'h4217;

  // Step periods and operation lengths.
  localparam logic [3:0] PeriodShort = 4'd6;
  localparam logic [3:0] PeriodLong  = 4'd8;
  localparam logic [3:0] MulSteps    = 4'd8;
  localparam logic [4:0] DivSteps    = 5'd16;

  // Reset values of the operand registers.
  localparam logic [7:0]  MultiplicandReset = 8'hFF;
  localparam logic [15:0] DividendReset     = 16'hFFFF;

  // Captured request.
  typedef struct packed {
    op_e         op;
    logic [15:0] addr;
    logic [7:0]  data;
    logic [3:0]  per;
    logic        was_busy;
  } bsmdu_req_t;

  // Control from the sequencer to the datapath and output stage.
  typedef struct packed {
    logic clk_en;
    logic apply_en;
    logic out_load;
  } bsmdu_ctrl_t;

  // Status from the datapath.
  typedef struct packed {
    logic busy;
    logic mul_active;
    logic div_active;
  } bsmdu_stat_t;

endpackage

@@ hw/rtl/bsmdu_seq.sv @@
// ----------------------------------------------------------------------------
// Multiply / divide unit sequencer
// Walks one request through its master clocks, the register write and the
// response hand-off.
// ----------------------------------------------------------------------------
module bsmdu_seq import bsmdu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  op_e         op_i,
  input  logic [3:0]  write_span_i,
  input  op_e         req_op_i,
  input  logic        out_free_i,
  output logic        idle_o,
  output bsmdu_ctrl_t ctrl_o
);

  seq_state_e state_q, state_d;
  logic [3:0] count_q, count_d;
  logic [3:0] start_count;

  // Number of master clocks the incoming request spans.
  always_comb begin
    case (op_i)
      OP_TICK:  start_count = 4'd1;
      OP_WRITE: start_count = write_span_i;
      default:  start_count = 4'd0;
    endcase
  end

  // State register and clock counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= 4'd0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  // Next state and control outputs.
  always_comb begin
    state_d         = state_q;
    count_d         = count_q;
    idle_o          = 1'b0;
    ctrl_o.clk_en   = 1'b0;
    ctrl_o.apply_en = 1'b0;
    ctrl_o.out_load = 1'b0;
    case (state_q)
      ST_IDLE: begin
        idle_o = 1'b1;
        if (accept_i) begin
          count_d = start_count;
          state_d = (start_count != 4'd0) ? ST_CLOCK : ST_APPLY;
        end
      end
      ST_CLOCK: begin
        ctrl_o.clk_en = 1'b1;
        count_d       = count_q - 4'd1;
        if (count_q == 4'd1) begin
          state_d = ST_APPLY;
        end
      end
      ST_APPLY: begin
        ctrl_o.apply_en = (req_op_i == OP_WRITE);
        state_d         = ST_RESP;
      end
      ST_RESP: begin
        if (out_free_i) begin
          ctrl_o.out_load = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

@@ hw/rtl/bsmdu_dp.sv @@
// ----------------------------------------------------------------------------
// Multiply / divide unit datapath
// Operand and result registers, the step timer and one shared add/subtract
// unit that performs a shift-add or a restoring-divide step.
// ----------------------------------------------------------------------------
module bsmdu_dp import bsmdu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  bsmdu_ctrl_t ctrl_i,
  input  bsmdu_req_t  req_i,
  output bsmdu_stat_t stat_o,
  output logic [7:0]  rd_byte_o
);

  logic [7:0]  mcand_q, mcand_d;
  logic [15:0] dvd_q, dvd_d;
  logic [15:0] quot_q, quot_d;
  logic [15:0] prem_q, prem_d;
  logic [23:0] shift_q, shift_d;
  logic [3:0]  mul_left_q, mul_left_d;
  logic [4:0]  div_left_q, div_left_d;
  logic [3:0]  period_q, period_d;
  logic [3:0]  resid_q, resid_d;

  logic        busy;
  logic        tick;
  logic        step;
  logic [4:0]  resid_inc;
  logic [4:0]  period_ext;
  logic [23:0] div_shift;
  logic [24:0] alu_a;
  logic [24:0] alu_b;
  logic [25:0] alu_sum;
  logic        div_ge;
  logic [3:0]  new_per;

  assign busy              = (mul_left_q != 4'd0) || (div_left_q != 5'd0);
  assign stat_o.busy       = busy;
  assign stat_o.mul_active = (mul_left_q != 4'd0);
  assign stat_o.div_active = (div_left_q != 5'd0);

  // Step timer: a step fires when the residue reaches the period.
  assign tick       = ctrl_i.clk_en && busy && (period_q != 4'd0);
  assign resid_inc  = {1'b0, resid_q} + 5'd1;
  assign period_ext = {1'b0, period_q};
  assign step       = tick && (resid_inc >= period_ext);

  // Shared adder: adds the shifter for a multiply step, subtracts the
  // shifted divisor for a divide step.
  assign div_shift = shift_q >> 1;
  always_comb begin
    alu_a = {9'd0, prem_q};
    if (mul_left_q != 4'd0) begin
      alu_b = {9'd0, shift_q[15:0]};
    end else begin
      alu_b = ~{1'b0, div_shift};
    end
  end
  assign alu_sum = {1'b0, alu_a} + {1'b0, alu_b} + {25'd0, (mul_left_q == 4'd0)};
  assign div_ge  = alu_sum[25];

  // Step period latched by a start.
  assign new_per = ((req_i.per == PeriodShort) || (req_i.per == PeriodLong)) ?
                   req_i.per : PeriodShort;

  // Next values of the unit registers.
  always_comb begin
    mcand_d    = mcand_q;
    dvd_d      = dvd_q;
    quot_d     = quot_q;
    prem_d     = prem_q;
    shift_d    = shift_q;
    mul_left_d = mul_left_q;
    div_left_d = div_left_q;
    period_d   = period_q;
    resid_d    = resid_q;

    // One master clock of a running operation.
    if (tick) begin
      if (step) begin
        resid_d = 4'(resid_inc - period_ext);
      end else begin
        resid_d = resid_inc[3:0];
      end
    end
    if (step && (mul_left_q != 4'd0)) begin
      mul_left_d = mul_left_q - 4'd1;
      if (quot_q[0]) begin
        prem_d = alu_sum[15:0];
      end
      shift_d = {shift_q[22:0], 1'b0};
      quot_d  = {1'b0, quot_q[15:1]};
    end
    if (step && (div_left_q != 5'd0)) begin
      div_left_d = div_left_q - 5'd1;
      shift_d    = div_shift;
      quot_d     = {quot_q[14:0], div_ge};
      if (div_ge) begin
        prem_d = alu_sum[15:0];
      end
    end

    // Register write after the write span has run.
    if (ctrl_i.apply_en) begin
      case (req_i.addr)
        AddrMultiplicand: begin
          mcand_d = req_i.data;
        end
        AddrMulStart: begin
          prem_d = 16'd0;
          if (!req_i.was_busy) begin
            mul_left_d = MulSteps;
            div_left_d = 5'd0;
            quot_d     = {req_i.data, mcand_q};
            shift_d    = {16'd0, req_i.data};
            period_d   = new_per;
            resid_d    = 4'd0;
          end else if (!busy) begin
            quot_d = {req_i.data, mcand_q};
          end
        end
        AddrDividendLo: begin
          dvd_d = {dvd_q[15:8], req_i.data};
        end
        AddrDividendHi: begin
          dvd_d = {req_i.data, dvd_q[7:0]};
        end
        AddrDivStart: begin
          prem_d = dvd_q;
          if (!req_i.was_busy) begin
            div_left_d = DivSteps;
            mul_left_d = 4'd0;
            shift_d    = {req_i.data, 16'd0};
            period_d   = new_per;
            resid_d    = 4'd0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Unit registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mcand_q    <= MultiplicandReset;
      dvd_q      <= DividendReset;
      quot_q     <= 16'd0;
      prem_q     <= 16'd0;
      shift_q    <= 24'd0;
      mul_left_q <= 4'd0;
      div_left_q <= 5'd0;
      period_q   <= 4'd0;
      resid_q    <= 4'd0;
    end else begin
      mcand_q    <= mcand_d;
      dvd_q      <= dvd_d;
      quot_q     <= quot_d;
      prem_q     <= prem_d;
      shift_q    <= shift_d;
      mul_left_q <= mul_left_d;
      div_left_q <= div_left_d;
      period_q   <= period_d;
      resid_q    <= resid_d;
    end
  end

  // Read data for a read request, zero otherwise.
  always_comb begin
    rd_byte_o = 8'd0;
    if (req_i.op == OP_READ) begin
      case (req_i.addr)
        AddrQuotLo:    rd_byte_o = quot_q[7:0];
        AddrQuotHi:    rd_byte_o = quot_q[15:8];
        AddrProdRemLo: rd_byte_o = prem_q[7:0];
        AddrProdRemHi: rd_byte_o = prem_q[15:8];
        default:       rd_byte_o = 8'd0;
      endcase
    end
  end

endmodule

@@ hw/rtl/bit_serial_mul_div_unit_top.sv @@
// ----------------------------------------------------------------------------
// Bit-serial multiply / divide unit
// Memory-mapped 8x8 shift-add multiply and 16/8 restoring divide with
// master-clock accurate step timing.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake             Payload
//   request   in         in_valid_i/in_stall_o op, addr, data, write_span,
//                                              step_period
//   response  out        out_valid_o/out_stall_i read_data, busy_res
//
// A request runs its master clocks, then the apply and response states; a write
// spans write_span master clocks, a read or an unknown op none. The sequencer
// runs one master clock per cycle through the shared step unit.
// The response register lets a new request be taken while a response waits;
// a request finishes only once the response register is free.
// Reset is asynchronous, active low, and returns the sequencer, the unit
// registers and the response valid flag to their power-on values.
// ----------------------------------------------------------------------------
module bit_serial_mul_div_unit_top import bsmdu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  op_i,
  input  logic [15:0] addr_i,
  input  logic [7:0]  data_i,
  input  logic [3:0]  write_span_i,
  input  logic [3:0]  step_period_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  read_data_o,
  output logic        busy_res_o
);

  bsmdu_req_t  req_q, req_d;
  bsmdu_ctrl_t ctrl;
  bsmdu_stat_t stat;
  logic        idle;
  logic        accept;
  logic        out_free;
  logic [7:0]  rd_byte;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  read_data_q;
  logic        busy_res_q;

  assign in_stall_o = !idle;
  assign accept     = in_valid_i && idle;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Request capture.
  always_comb begin
    req_d = req_q;
    if (accept) begin
      req_d.op       = op_e'(op_i);
      req_d.addr     = addr_i;
      req_d.data     = data_i;
      req_d.per      = step_period_i;
      req_d.was_busy = stat.busy;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
  end

  // Sequencer.
  bsmdu_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .op_i         (op_e'(op_i)),
    .write_span_i (write_span_i),
    .req_op_i     (req_q.op),
    .out_free_i   (out_free),
    .idle_o       (idle),
    .ctrl_o       (ctrl)
  );

  // Datapath.
  bsmdu_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .req_i     (req_q),
    .stat_o    (stat),
    .rd_byte_o (rd_byte)
  );

  // Response register.
  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.out_load) begin
      read_data_q <= rd_byte;
      busy_res_q  <= stat.busy;
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = read_data_q;
  assign busy_res_o  = busy_res_q;

  // A multiply and a divide never run at the same time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(stat.mul_active && stat.div_active))
    else $error("multiply and divide both active");

  // A response never overwrites one that is still stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.out_load |-> out_free)
    else $error("response loaded over a stalled response");

  // The register write and a master clock never share a cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl.apply_en && ctrl.clk_en))
    else $error("write applied during a master clock");

  // An accepted request blocks the next one in the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> in_stall_o)
    else $error("request accepted back to back");

endmodule
